// ===== hw/rtl/avm_pkg.sv =====
// Package with the payload types, register indexes and constants of the airspeed validity monitor.
package avm_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned RATIO_W = 10;
  localparam int unsigned DELAY_W = 27;

  // Datapath widths of the load filter
  localparam int unsigned C2_W   = 30;  // calibrated speed squared
  localparam int unsigned DEN_W  = 47;  // 98100 * C^2
  localparam int unsigned HIST_W = 27;  // 93195 * r or 500 * A
  localparam int unsigned NUM_W  = 58;  // full numerator and remainder
  localparam int unsigned QUO_W  = RATIO_W + 1;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_STUCK_EN     = 3'd0;
  localparam logic [2:0] REG_LOAD_EN      = 3'd1;
  localparam logic [2:0] REG_STALL_SPEED  = 3'd2;
  localparam logic [2:0] REG_STUCK_TMO    = 3'd3;
  localparam logic [2:0] REG_FAIL_DELAY   = 3'd4;
  localparam logic [2:0] REG_CLEAR_DELAY  = 3'd5;

  // Reset values of the registers
  localparam logic [SPEED_W-1:0] STALL_SPEED_RST = 16'd2560;
  localparam logic [DELAY_W-1:0] STUCK_TMO_RST   = 27'd2000000;
  localparam logic [DELAY_W-1:0] FAIL_DELAY_RST  = 27'd2000000;
  localparam logic [DELAY_W-1:0] CLEAR_DELAY_RST = 27'd0;

  // Filter constants
  localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd128;
  localparam logic [RATIO_W-1:0] RATIO_MIN   = 10'd64;
  localparam logic [RATIO_W-1:0] RATIO_MAX   = 10'd512;
  localparam logic [RATIO_W-1:0] RATIO_FAIL  = 10'd282;
  localparam logic [SPEED_W-1:0] CAS_FLOOR   = 16'd179;
  localparam logic [SPEED_W-1:0] STALL_FLOOR = 16'd256;
  localparam logic [31:0]        MUL_DEN     = 32'd98100;  // 100 * 981
  localparam logic [31:0]        MUL_HIST    = 32'd93195;  // 95 * 981
  localparam logic [31:0]        MUL_NEW     = 32'd500;

  // Last step indexes of the multiply and divide phases
  localparam logic [3:0] MUL_LAST = 4'd6;
  localparam logic [3:0] DIV_LAST = 4'd10;

  // Input beat
  typedef struct packed {
    logic                      mode;
    logic [TIME_W-1:0]         timestamp_us;
    logic signed [SPEED_W-1:0] indicated_speed;
    logic signed [SPEED_W-1:0] calibrated_speed;
    logic signed [SPEED_W-1:0] accel_vertical;
    logic                      fixed_wing_flight;
    logic                      innovation_failed;
    logic                      principle_failed;
  } avm_in_t;

  // Result beat
  typedef struct packed {
    logic               airspeed_valid;
    logic               stuck_failed;
    logic               load_failed;
    logic [RATIO_W-1:0] load_ratio;
  } avm_out_t;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ADD1 = 6'b000100,
    ST_ADD2 = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } avm_state_e;

endpackage

// ===== hw/rtl/airspeed_validity_monitor_core.sv =====
// Top level of the airspeed validity monitor: sequencer, shared multiplier and divider, checks.
// For each input beat the sequencer runs seven steps of the shared 32x32 multiplier, two accumulate
// steps, eleven restoring division steps and a finishing step. A new input beat is taken only
// once the sequencer is idle again, and the finishing step waits while the output is stalled.
// An output register holds the result, so the next beat is taken while it waits.
// Reset (rst_ni low, asynchronous) returns the registers to their defaults and the monitor
// state to its initial values, with the load ratio at 0.5.
module airspeed_validity_monitor_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  avm_pkg::avm_in_t     in_data_i,
  // Output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output avm_pkg::avm_out_t    out_data_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import avm_pkg::*;

  // Configuration registers
  logic               stuck_en_q;
  logic               load_en_q;
  logic [SPEED_W-1:0] stall_speed_q;
  logic [DELAY_W-1:0] stuck_tmo_q;
  logic [DELAY_W-1:0] fail_delay_q;
  logic [DELAY_W-1:0] clear_delay_q;

  // Monitor state
  logic [SPEED_W-1:0] last_speed_q;
  logic [TIME_W-1:0]  change_time_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [TIME_W-1:0]  pass_time_q;
  logic [TIME_W-1:0]  fail_time_q;
  logic               valid_q;
  logic               stuck_q;
  logic               load_q;

  // Sequencer and datapath
  avm_state_e         state_q, state_d;
  logic [3:0]         step_q;
  avm_in_t            in_q;
  logic [C2_W-1:0]    c2_q;
  logic [DEN_W-1:0]   den_q;
  logic [HIST_W-1:0]  k_q;
  logic [NUM_W-2:0]   p1_q;
  logic [31:0]        s2_q;
  logic [NUM_W-1:0]   num_q;
  logic [NUM_W-2:0]   dsh_q;
  logic [QUO_W-1:0]   quo_q;
  logic               stuck_el_q;
  logic               pass_tmo_q;
  logic               fail_tmo_q;

  // Result register
  logic               out_valid_q;
  avm_out_t           out_q;

  logic in_accept;
  logic cfg_write;
  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign pready = 1'b1;

  // Register read mux
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_STUCK_EN:    prdata = {31'd0, stuck_en_q};
      REG_LOAD_EN:     prdata = {31'd0, load_en_q};
      REG_STALL_SPEED: prdata = {16'd0, stall_speed_q};
      REG_STUCK_TMO:   prdata = {5'd0, stuck_tmo_q};
      REG_FAIL_DELAY:  prdata = {5'd0, fail_delay_q};
      REG_CLEAR_DELAY: prdata = {5'd0, clear_delay_q};
      default:         prdata = '0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_en_q    <= 1'b1;
      load_en_q     <= 1'b1;
      stall_speed_q <= STALL_SPEED_RST;
      stuck_tmo_q   <= STUCK_TMO_RST;
      fail_delay_q  <= FAIL_DELAY_RST;
      clear_delay_q <= CLEAR_DELAY_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_STUCK_EN:    stuck_en_q    <= pwdata[0];
        REG_LOAD_EN:     load_en_q     <= pwdata[0];
        REG_STALL_SPEED: stall_speed_q <= pwdata[SPEED_W-1:0];
        REG_STUCK_TMO:   stuck_tmo_q   <= pwdata[DELAY_W-1:0];
        REG_FAIL_DELAY:  fail_delay_q  <= pwdata[DELAY_W-1:0];
        REG_CLEAR_DELAY: clear_delay_q <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Floored and rectified filter operands
  logic [SPEED_W-1:0] cas_u, az_u, acc_abs, stall_fl;
  logic [14:0]        cas_fl;
  assign cas_u    = in_q.calibrated_speed;
  assign az_u     = in_q.accel_vertical;
  assign acc_abs  = az_u[15] ? (~az_u + 16'd1) : az_u;
  assign stall_fl = (stall_speed_q < STALL_FLOOR) ? STALL_FLOOR : stall_speed_q;
  assign cas_fl   = (cas_u[15] || cas_u < CAS_FLOOR) ? CAS_FLOOR[14:0] : cas_u[14:0];

  // Shared multiplier with operands chosen by the step counter
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      4'd0:    begin mul_a = {17'd0, cas_fl};   mul_b = {17'd0, cas_fl};        end
      4'd1:    begin mul_a = MUL_DEN;           mul_b = {2'd0, c2_q};           end
      4'd2:    begin mul_a = MUL_HIST;          mul_b = {22'd0, ratio_q};       end
      4'd3:    begin mul_a = {5'd0, k_q};       mul_b = {2'd0, c2_q};           end
      4'd4:    begin mul_a = {16'd0, stall_fl}; mul_b = {16'd0, stall_fl};      end
      4'd5:    begin mul_a = MUL_NEW;           mul_b = {16'd0, acc_abs};       end
      4'd6:    begin mul_a = {5'd0, k_q};       mul_b = s2_q;                   end
      default: begin mul_a = '0;                mul_b = '0;                     end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Shared elapsed-time compare, used in the first three multiplier steps
  logic [TIME_W-1:0]  el_then, el_diff;
  logic [DELAY_W-1:0] el_lim;
  logic               el_over;
  always_comb begin
    el_then = change_time_q;
    el_lim  = stuck_tmo_q;
    case (step_q)
      4'd1:    begin el_then = pass_time_q; el_lim = fail_delay_q;  end
      4'd2:    begin el_then = fail_time_q; el_lim = clear_delay_q; end
      default: begin el_then = change_time_q; el_lim = stuck_tmo_q; end
    endcase
  end
  assign el_diff = in_q.timestamp_us - el_then;
  assign el_over = el_diff > {{(TIME_W-DELAY_W){1'b0}}, el_lim};

  // Division step compare
  logic div_ge;
  assign div_ge = num_q >= {1'b0, dsh_q};

  // Clamped filter result
  logic [RATIO_W-1:0] ratio_new;
  always_comb begin
    if (quo_q[QUO_W-1]) begin
      ratio_new = RATIO_MAX;
    end else if (quo_q[RATIO_W-1:0] < RATIO_MIN) begin
      ratio_new = RATIO_MIN;
    end else if (quo_q[RATIO_W-1:0] > RATIO_MAX) begin
      ratio_new = RATIO_MAX;
    end else begin
      ratio_new = quo_q[RATIO_W-1:0];
    end
  end

  // Check and validity decisions for the finishing step
  logic               fin_go;
  logic               speed_upd;
  logic               stuck_n, load_n, fail_now, valid_n;
  logic [RATIO_W-1:0] ratio_n;
  assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign speed_upd = (in_q.indicated_speed != last_speed_q) || (change_time_q == '0);
  always_comb begin
    stuck_n = stuck_en_q && in_q.fixed_wing_flight && !speed_upd && stuck_el_q;
    ratio_n = RATIO_RESET;
    load_n  = load_q;
    if (!load_en_q) begin
      load_n = 1'b0;
    end else if (in_q.fixed_wing_flight) begin
      ratio_n = ratio_new;
      load_n  = ratio_new >= RATIO_FAIL;
    end
    fail_now = stuck_n || in_q.innovation_failed || load_n || in_q.principle_failed;
    valid_n  = valid_q;
    if (valid_q) begin
      if ((in_q.innovation_failed && load_n) || (fail_now && pass_tmo_q) || stuck_n) begin
        valid_n = 1'b0;
      end
    end else if (clear_delay_q != '0 && !fail_now && fail_tmo_q) begin
      valid_n = 1'b1;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_MUL;
      ST_MUL:  if (step_q == MUL_LAST) state_d = ST_ADD1;
      ST_ADD1: state_d = ST_ADD2;
      ST_ADD2: state_d = ST_DIV;
      ST_DIV:  if (step_q == DIV_LAST) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  // Datapath registers: capture, multiply, accumulate and divide
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (state_q == ST_MUL) begin
      case (step_q)
        4'd0:    begin c2_q <= prod[C2_W-1:0];    stuck_el_q <= el_over; end
        4'd1:    begin den_q <= prod[DEN_W-1:0];  pass_tmo_q <= el_over; end
        4'd2:    begin k_q <= prod[HIST_W-1:0];   fail_tmo_q <= el_over; end
        4'd3:    p1_q  <= prod[NUM_W-2:0];
        4'd4:    s2_q  <= prod[31:0];
        4'd5:    k_q   <= prod[HIST_W-1:0];
        4'd6:    num_q <= {1'b0, prod[NUM_W-2:0]};
        default: ;
      endcase
    end
    if (state_q == ST_ADD1) begin
      num_q <= num_q + {1'b0, p1_q};
    end
    if (state_q == ST_ADD2) begin
      num_q <= num_q + {{(NUM_W-DEN_W+1){1'b0}}, den_q[DEN_W-1:1]};
      dsh_q <= {den_q, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end
    if (state_q == ST_DIV) begin
      if (div_ge) begin
        num_q <= num_q - {1'b0, dsh_q};
      end
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
      dsh_q <= {1'b0, dsh_q[NUM_W-2:1]};
    end
  end

  // Monitor state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_speed_q  <= '0;
      change_time_q <= '0;
      ratio_q       <= RATIO_RESET;
      pass_time_q   <= '0;
      fail_time_q   <= '0;
      valid_q       <= 1'b0;
      stuck_q       <= 1'b0;
      load_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin_go) begin
        if (in_q.mode) begin
          // Forced invalid: checks do not run, flags and ratio are held.
          valid_q     <= 1'b0;
          fail_time_q <= in_q.timestamp_us;
          out_q       <= '{airspeed_valid: 1'b0, stuck_failed: stuck_q,
                           load_failed: load_q, load_ratio: ratio_q};
        end else begin
          if (stuck_en_q && speed_upd) begin
            change_time_q <= in_q.timestamp_us;
            last_speed_q  <= in_q.indicated_speed;
          end
          if (fail_now) begin
            fail_time_q <= in_q.timestamp_us;
          end else begin
            pass_time_q <= in_q.timestamp_us;
          end
          stuck_q <= stuck_n;
          load_q  <= load_n;
          ratio_q <= ratio_n;
          valid_q <= valid_n;
          out_q   <= '{airspeed_valid: valid_n, stuck_failed: stuck_n,
                       load_failed: load_n, load_ratio: ratio_n};
        end
      end
    end
  end

endmodule
